/* hdl/opwd_pkg.sv */
// ----------------------------------------------------------------------------
// opwd_pkg
// Shared types and constants for the on-off-keyed pulse width decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package opwd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int GAP_W       = 20;
    localparam int PULSE_W     = 16;
    localparam int COUNT_W     = 6;
    localparam int TIME_W      = 32;
    localparam int PACKET_W    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register map of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAP_THRESHOLD = 3'd0,
        REG_LONG_LOW      = 3'd1,
        REG_LONG_HIGH     = 3'd2,
        REG_SHORT_LOW     = 3'd3,
        REG_SHORT_HIGH    = 3'd4,
        REG_MIN_BITS      = 3'd5
    } reg_index_t;

    localparam logic [GAP_W-1:0]   GAP_THRESHOLD_RST = 20'd7000;
    localparam logic [PULSE_W-1:0] LONG_LOW_RST      = 16'd690;
    localparam logic [PULSE_W-1:0] LONG_HIGH_RST     = 16'd1100;
    localparam logic [PULSE_W-1:0] SHORT_LOW_RST     = 16'd180;
    localparam logic [PULSE_W-1:0] SHORT_HIGH_RST    = 16'd400;
    localparam logic [COUNT_W-1:0] MIN_BITS_RST      = 6'd10;

    typedef struct packed {
        logic [GAP_W-1:0]   gap_threshold;
        logic [PULSE_W-1:0] long_low;
        logic [PULSE_W-1:0] long_high;
        logic [PULSE_W-1:0] short_low;
        logic [PULSE_W-1:0] short_high;
        logic [COUNT_W-1:0] min_bits;
    } cfg_t;

endpackage

`default_nettype wire

/* hdl/opwd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// opwd_cfg_regs
// Configuration register file: write-only, decoded by register index.
// ----------------------------------------------------------------------------
`default_nettype none

module opwd_cfg_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [opwd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [opwd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output opwd_pkg::cfg_t                         cfg
);

    opwd_pkg::cfg_t cfg_reg;
    opwd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (opwd_pkg::reg_index_t'(cfg_index))
                opwd_pkg::REG_GAP_THRESHOLD:
                    cfg_next.gap_threshold = cfg_data[opwd_pkg::GAP_W-1:0];
                opwd_pkg::REG_LONG_LOW:
                    cfg_next.long_low = cfg_data[opwd_pkg::PULSE_W-1:0];
                opwd_pkg::REG_LONG_HIGH:
                    cfg_next.long_high = cfg_data[opwd_pkg::PULSE_W-1:0];
                opwd_pkg::REG_SHORT_LOW:
                    cfg_next.short_low = cfg_data[opwd_pkg::PULSE_W-1:0];
                opwd_pkg::REG_SHORT_HIGH:
                    cfg_next.short_high = cfg_data[opwd_pkg::PULSE_W-1:0];
                opwd_pkg::REG_MIN_BITS:
                    cfg_next.min_bits = cfg_data[opwd_pkg::COUNT_W-1:0];
                default:
                    cfg_next = cfg_reg;   // unmapped index: drop the write
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_threshold <= opwd_pkg::GAP_THRESHOLD_RST;
            cfg_reg.long_low      <= opwd_pkg::LONG_LOW_RST;
            cfg_reg.long_high     <= opwd_pkg::LONG_HIGH_RST;
            cfg_reg.short_low     <= opwd_pkg::SHORT_LOW_RST;
            cfg_reg.short_high    <= opwd_pkg::SHORT_HIGH_RST;
            cfg_reg.min_bits      <= opwd_pkg::MIN_BITS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/ook_pulse_width_decoder.sv */
// ----------------------------------------------------------------------------
// ook_pulse_width_decoder
// Turns timestamped receiver pin edges into decoded on-off-keyed packets.
// ----------------------------------------------------------------------------
// Each item is one pin edge; edges alternate rising and falling, starting
// with a rising edge, and items with pin_event low are dropped at the input.
// A falling edge classifies the high pulse as a long (1) or short (0) bit or
// discards the packet; a rising edge after a low gap above gap_threshold ends
// the packet and emits it if it holds more than min_bits bits. One item is
// taken per cycle unless in_stall holds the input: an edge goes through an
// input register and subtract-and-compare logic into the state and the
// result register, which drives out_valid. in_stall rises only when a held
// edge would emit a packet while the result register is still stalled.
// The user must write configuration only while the decoder is idle; the
// block itself does not enforce it.
`default_nettype none

module ook_pulse_width_decoder
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_we,
    input  wire logic [opwd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [opwd_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic                              pin_event,
    input  wire logic [opwd_pkg::TIME_W-1:0]       timestamp,

    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [opwd_pkg::PACKET_W-1:0]     packet_word,
    output      logic [opwd_pkg::COUNT_W-1:0]      packet_length
);

    localparam int TW = opwd_pkg::TIME_W;
    localparam int CW = opwd_pkg::COUNT_W;

    opwd_pkg::cfg_t cfg;

    opwd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register
    logic          in_vld_reg;
    logic [TW-1:0] ts_reg;

    // Decoder state
    logic                 expect_rise_reg, expect_rise_next;
    logic [TW-1:0]        rise_time_reg, rise_time_next;
    logic [TW-1:0]        fall_time_reg, fall_time_next;
    logic [WORD_BITS-1:0] shift_word_reg, shift_word_next;
    logic [CW-1:0]        bit_pos_reg, bit_pos_next;

    // Result register
    logic                              out_vld_reg, out_vld_next;
    logic [opwd_pkg::PACKET_W-1:0]     out_word_reg, out_word_next;
    logic [CW-1:0]                     out_len_reg, out_len_next;

    logic          fire;
    logic          emit;
    logic          gap_end;
    logic          is_long;
    logic          is_short;
    logic [TW-1:0] width;
    logic [WORD_BITS-1:0] bit_mask;
    logic          in_store;

    // Pulse or gap width since the opposite edge, modulo 2^32
    assign width = ts_reg - (expect_rise_reg ? fall_time_reg : rise_time_reg);

    assign gap_end  = width > TW'(cfg.gap_threshold);
    assign is_long  = (width > TW'(cfg.long_low)) && (width < TW'(cfg.long_high));
    assign is_short = (width <= TW'(cfg.short_high)) && (width >= TW'(cfg.short_low));
    assign emit     = expect_rise_reg && gap_end && (bit_pos_reg > cfg.min_bits);

    // Hold the edge only when it would emit into a stalled result register
    assign fire     = in_vld_reg && (!emit || !out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !fire;
    assign in_store = {1'b0, bit_pos_reg} < (CW + 1)'(WORD_BITS);

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            bit_mask[i] = (bit_pos_reg == CW'(i));
        end
    end

    always_comb
    begin
        expect_rise_next = expect_rise_reg;
        rise_time_next   = rise_time_reg;
        fall_time_next   = fall_time_reg;
        shift_word_next  = shift_word_reg;
        bit_pos_next     = bit_pos_reg;
        if (fire)
        begin
            expect_rise_next = !expect_rise_reg;
            if (expect_rise_reg)
            begin
                rise_time_next = ts_reg;
                if (gap_end)
                begin
                    shift_word_next = '0;
                    bit_pos_next    = '0;
                end
            end
            else
            begin
                fall_time_next = ts_reg;
                if (is_long || is_short)
                begin
                    if (is_long && in_store)
                    begin
                        shift_word_next = shift_word_reg | bit_mask;
                    end
                    // saturate the count
                    if (bit_pos_reg != opwd_pkg::COUNT_MAX)
                    begin
                        bit_pos_next = bit_pos_reg + CW'(1);
                    end
                end
                else
                begin
                    shift_word_next = '0;
                    bit_pos_next    = '0;
                end
            end
        end
    end

    always_comb
    begin
        out_word_next = out_word_reg;
        out_len_next  = out_len_reg;
        if (fire && emit)
        begin
            out_vld_next  = 1'b1;
            out_word_next = opwd_pkg::PACKET_W'(shift_word_reg);
            out_len_next  = bit_pos_reg;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            expect_rise_reg <= 1'b1;
            rise_time_reg   <= '0;
            fall_time_reg   <= '0;
            shift_word_reg  <= '0;
            bit_pos_reg     <= '0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_vld_reg <= in_valid && pin_event;   // drop ignored edges here
            end
            expect_rise_reg <= expect_rise_next;
            rise_time_reg   <= rise_time_next;
            fall_time_reg   <= fall_time_next;
            shift_word_reg  <= shift_word_next;
            bit_pos_reg     <= bit_pos_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            ts_reg <= timestamp;
        end
        out_word_reg <= out_word_next;
        out_len_reg  <= out_len_next;
    end

    assign out_valid     = out_vld_reg;
    assign packet_word   = out_word_reg;
    assign packet_length = out_len_reg;

endmodule

`default_nettype wire
